FILE: rtl/rsl_ie_pkg.sv
// Package with types, constants and type-code helpers for the RSL element parser.
`timescale 1ns / 1ps
`default_nettype none

package rsl_ie_pkg;

    // Elements accepted per message before the rest of the message is skipped.
    localparam int unsigned MaxIes = 32;

    localparam int unsigned SDataW = 8;
    localparam int unsigned MDataW = 56;
    localparam int unsigned MUserW = 1;
    localparam int unsigned CountW = 6;

    localparam logic [7:0] TYPE_TL16V_A = 8'h30;
    localparam logic [7:0] TYPE_TL16V_B = 8'h32;
    localparam logic [7:0] LEN_CLIP_MAX = 8'd255;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_TYPE     = 3'd0,
        PH_TV_VALUE = 3'd1,
        PH_LEN_HI   = 3'd2,
        PH_LEN_LO   = 3'd3,
        PH_LEN8     = 3'd4,
        PH_VALUE    = 3'd5
    } t_phase;

    typedef struct packed {
        logic              position_overflow;
        logic              truncated;
        logic [CountW-1:0] element_count;
        logic              message_end;
        logic [15:0]       value_offset;
        logic [7:0]        element_length_clipped;
        logic [15:0]       element_length;
        logic [7:0]        element_type;
        logic              element_valid;
    } t_result;

    // Type codes whose value is a single byte with no length field.
    function automatic logic is_tv_type(input logic [7:0] t);
        logic r;
        case (t)
            8'h11, 8'h12, 8'h21, 8'h24, 8'h25, 8'h26, 8'h28, 8'h29,
            8'h2d, 8'h2e, 8'h31, 8'h33, 8'h36, 8'h37, 8'h38: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_tl16v_type(input logic [7:0] t);
        return (t == TYPE_TL16V_A) || (t == TYPE_TL16V_B);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rsl_ie_tlv_parser_unit.sv
// Top level of the RSL information element parser: byte stream in, element reports out.
//
//  channel   | dir | tdata                                   | tuser         | tlast
//  ----------+-----+-----------------------------------------+---------------+-------------
//  s (bytes) | in  | [7:0] payload byte                      | -             | last byte
//  m (items) | out | type, length, clipped length, offset,   | element valid | message end
//            |     | count, truncated, position overflow     |               |
//
// Each byte is parsed in the cycle it is accepted. Results go to the single result register;
// a second skid register takes one result while the output is held, so input keeps flowing
// at one byte per cycle until the skid register is full.
// o_s_tready drops only while the skid register holds a result.
// Reset (synchronous, active low) returns the parser to expecting a type byte.
`timescale 1ns / 1ps
`default_nettype none

module rsl_ie_tlv_parser_unit (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    input  wire logic [rsl_ie_pkg::SDataW-1:0]    i_s_tdata,   // [7:0] payload_byte
    input  wire logic                             i_s_tlast,   // last_byte
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [7:0] element_type, [23:8] element_length, [31:24] element_length_clipped,
    // [47:32] value_offset, [53:48] element_count, [54] truncated,
    // [55] position_overflow
    output logic      [rsl_ie_pkg::MDataW-1:0]    o_m_tdata,
    output logic      [rsl_ie_pkg::MUserW-1:0]    o_m_tuser,   // [0] element_valid
    output logic                                  o_m_tlast    // message_end
);

    import rsl_ie_pkg::*;

    t_phase            r_phase, n_phase;
    logic [7:0]        r_type, n_type;
    logic [15:0]       r_len, n_len;
    logic [15:0]       r_remain, n_remain;
    logic [15:0]       r_vstart, n_vstart;
    logic [15:0]       r_pos, n_pos;
    logic [CountW-1:0] r_found, n_found;
    logic              r_stopped, n_stopped;
    logic              r_ovf, n_ovf;

    t_result           r_out, r_skid, res;
    logic              r_out_valid, r_skid_valid;

    logic              s_accept, m_take, produce;
    logic              emit;
    logic [15:0]       e_len;
    logic [15:0]       len_now;
    logic [15:0]       remain_dec;
    logic [CountW-1:0] found_inc;
    logic [7:0]        b;

    assign b          = i_s_tdata;
    assign o_s_tready = !r_skid_valid;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign m_take     = r_out_valid && i_m_tready;
    assign remain_dec = r_remain - 16'd1;
    assign found_inc  = r_found + CountW'(1);
    assign len_now    = (r_phase == PH_LEN_LO) ? {r_len[15:8], b} : {8'd0, b};

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        if (!r_stopped) begin
            case (r_phase)
                PH_TV_VALUE: n_phase = PH_TYPE;
                PH_LEN_HI:   n_phase = PH_LEN_LO;
                PH_LEN_LO, PH_LEN8: begin
                    n_phase = (len_now == 16'd0) ? PH_TYPE : PH_VALUE;
                end
                PH_VALUE: begin
                    if (remain_dec == 16'd0) n_phase = PH_TYPE;
                end
                default: begin
                    if (is_tv_type(b))         n_phase = PH_TV_VALUE;
                    else if (is_tl16v_type(b)) n_phase = PH_LEN_HI;
                    else                       n_phase = PH_LEN8;
                end
            endcase
        end
    end

    // Datapath updates and element detection.
    always_comb begin
        n_type    = r_type;
        n_len     = r_len;
        n_remain  = r_remain;
        n_vstart  = r_vstart;
        n_found   = r_found;
        n_stopped = r_stopped;
        emit      = 1'b0;
        e_len     = 16'd0;
        n_ovf     = r_ovf || (r_pos == POS_MAX);
        n_pos     = (r_pos == POS_MAX) ? POS_MAX : r_pos + 16'd1;
        if (!r_stopped) begin
            case (r_phase)
                PH_TV_VALUE: begin
                    n_vstart = r_pos;
                    e_len    = 16'd1;
                    emit     = 1'b1;
                end
                PH_LEN_HI: n_len = {b, 8'd0};
                PH_LEN_LO, PH_LEN8: begin
                    n_len    = len_now;
                    n_vstart = n_pos;
                    if (len_now == 16'd0) emit = 1'b1;
                    else                  n_remain = len_now;
                end
                PH_VALUE: begin
                    n_remain = remain_dec;
                    if (remain_dec == 16'd0) begin
                        e_len = r_len;
                        emit  = 1'b1;
                    end
                end
                default: n_type = b;
            endcase
            if (emit) begin
                n_found = found_inc;
                if (32'(found_inc) >= MaxIes) n_stopped = 1'b1;
            end
        end
    end

    // Result assembled for the byte being accepted.
    always_comb begin
        res.element_valid          = emit;
        res.element_type           = emit ? r_type : 8'd0;
        res.element_length         = e_len;
        res.element_length_clipped = (e_len[15:8] != 8'd0) ? LEN_CLIP_MAX : e_len[7:0];
        res.value_offset           = emit ? n_vstart : 16'd0;
        res.message_end            = i_s_tlast;
        res.element_count          = n_found;
        res.truncated              = i_s_tlast && !n_stopped && (n_phase != PH_TYPE);
        res.position_overflow      = n_ovf;
    end

    assign produce = s_accept && (emit || i_s_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_TYPE;
            r_type    <= 8'd0;
            r_len     <= 16'd0;
            r_remain  <= 16'd0;
            r_vstart  <= 16'd0;
            r_pos     <= 16'd0;
            r_found   <= '0;
            r_stopped <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (s_accept) begin
            if (i_s_tlast) begin
                r_phase   <= PH_TYPE;
                r_type    <= 8'd0;
                r_len     <= 16'd0;
                r_remain  <= 16'd0;
                r_vstart  <= 16'd0;
                r_pos     <= 16'd0;
                r_found   <= '0;
                r_stopped <= 1'b0;
                r_ovf     <= 1'b0;
            end else begin
                r_phase   <= n_phase;
                r_type    <= n_type;
                r_len     <= n_len;
                r_remain  <= n_remain;
                r_vstart  <= n_vstart;
                r_pos     <= n_pos;
                r_found   <= n_found;
                r_stopped <= n_stopped;
                r_ovf     <= n_ovf;
            end
        end
    end

    // Output register with a skid register behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= produce;
            end
        end else if (produce) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (produce) begin
            r_skid <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.element_valid;
    assign o_m_tlast  = r_out.message_end;
    assign o_m_tdata  = {r_out.position_overflow, r_out.truncated, r_out.element_count,
                         r_out.value_offset, r_out.element_length_clipped,
                         r_out.element_length, r_out.element_type};

    // The skid register is only filled behind a held output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    // The element count never passes the per-message limit.
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_found) <= MaxIes)
        else $error("element count exceeds the limit");

    // A result without an element only reports the end of a message.
    a_empty_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("result without element outside message end");

    // Once stopped, the parser stays stopped until the message ends.
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !(s_accept && i_s_tlast)) |=> r_stopped)
        else $error("parser left the stopped state inside a message");

endmodule

`default_nettype wire
